// File: hdl/dccg_pkg.sv
`default_nettype none

package dccg_pkg;

  typedef struct packed {
    logic        fwd_button;
    logic        back_button;
    logic        left_button;
    logic        right_button;
    logic        echo_new;
    logic [14:0] echo_us;
  } in_t;

  typedef struct packed {
    logic [1:0] right_dir;
    logic [7:0] right_duty;
    logic [1:0] left_dir;
    logic [7:0] left_duty;
    logic       emergency_active;
    logic [9:0] distance_now;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MS_ECHO,
    MS_SPEED,
    MS_SQUARE,
    MS_RANGE,
    MS_DECEL,
    MS_MARGIN,
    MS_COMPARE
  } step_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BRAKE,
    PH_REVERSE,
    PH_SETTLE
  } phase_t;

  typedef enum logic [2:0] {
    CFG_DRIVE_DUTY,
    CFG_SPIN_DUTY,
    CFG_TRIM_RIGHT,
    CFG_TRIM_LEFT,
    CFG_SPEED_PER_STEP,
    CFG_BRAKE_DECEL,
    CFG_REVERSE_DUTY,
    CFG_REVERSE_MS
  } cfg_idx_t;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_BRAKE = 2'd2;
  localparam logic [1:0] DIR_COAST = 2'd3;

  localparam logic [9:0] FAR_CM       = 10'd999;
  localparam logic [9:0] BRAKE_TICKS  = 10'd30;
  localparam logic [9:0] SETTLE_TICKS = 10'd80;

  // floor(x / 58) == (x * 36158) >> 21 for any 15-bit x
  localparam logic [27:0] RECIP_58      = 28'd36158;
  localparam int          RECIP_SHIFT   = 21;
  localparam logic [27:0] UM20_PER_CM   = 28'd200000;
  localparam logic [27:0] DECEL_SCALE   = 28'd100;
  localparam logic [24:0] MARGIN_FLOOR  = 25'd4000000;

  localparam logic [7:0]  RST_DRIVE_DUTY   = 8'd255;
  localparam logic [7:0]  RST_SPIN_DUTY    = 8'd200;
  localparam logic [8:0]  RST_TRIM_RIGHT   = 9'h1DD;
  localparam logic [8:0]  RST_TRIM_LEFT    = 9'h000;
  localparam logic [13:0] RST_SPEED_STEP   = 14'd1300;
  localparam logic [13:0] RST_BRAKE_DECEL  = 14'd800;
  localparam logic [7:0]  RST_REVERSE_DUTY = 8'd160;
  localparam logic [9:0]  RST_REVERSE_MS   = 10'd180;

  function automatic logic [7:0] trimmed(input logic [7:0] speed, input logic [8:0] trim);
    logic signed [9:0] s;
    s = signed'({2'b00, speed}) + signed'({trim[8], trim});
    if (s < 10'sd0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'hFF;
    end
    return s[7:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/drive_command_collision_guard_core.sv
// One beat in gives one beat out. Each tick passes through the idle state
// that ends in acceptance, seven sequencer steps that share a single
// registered 22x28 multiplier (echo to centimeters, speed, speed squared, range,
// deceleration scale, stopping margin, final compare), and the finish state
// that updates the guard phase and loads the result into the output register.
// in_stall is high outside the idle state, so no new beat is taken before the
// result is loaded, and the finish state waits while an earlier result is still stalled at the output.
`default_nettype none

module drive_command_collision_guard_core #(
  parameter int unsigned ECHO_TIMEOUT_US = 25000
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dccg_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dccg_pkg::out_t       out_data,
  input  wire logic            cfg_psel,
  input  wire logic            cfg_penable,
  input  wire logic            cfg_pwrite,
  input  wire logic [4:0]      cfg_paddr,
  input  wire logic [31:0]     cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  dccg_pkg::state_t state_r, state_nxt;
  dccg_pkg::step_t  step_r, step_nxt;
  dccg_pkg::in_t    item_r;
  dccg_pkg::out_t   out_r, out_nxt;
  logic             out_valid_r;

  logic [7:0]  drive_duty_r, spin_duty_r, reverse_duty_r;
  logic [8:0]  trim_right_r, trim_left_r;
  logic [13:0] speed_step_r, brake_decel_r;
  logic [9:0]  reverse_ms_r;

  logic [9:0]          cm_r;
  dccg_pkg::phase_t    phase_r, phase_nxt;
  logic [9:0]          ticks_r, ticks_nxt;
  logic [1:0]          held_rd_r, held_ld_r;

  logic [21:0] mul_a;
  logic [27:0] mul_b;
  logic [49:0] prod_r;
  logic [43:0] vsq_r;
  logic [24:0] b20_r;
  logic [27:0] w_r;
  logic        wpos_r;
  logic        clear_r;

  logic        cfg_wr;
  logic        accept;
  logic        load;
  logic [9:0]  arc_sum;
  logic [7:0]  arc;
  logic [7:0]  pwm, rs, ls;
  logic        arc_left, arc_right;
  logic [13:0] decel;
  logic [24:0] seven_v;
  logic [27:0] range_um;
  logic        echo_timeout;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != dccg_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign load       = (state_r == dccg_pkg::ST_FINISH) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_duty_r   <= dccg_pkg::RST_DRIVE_DUTY;
      spin_duty_r    <= dccg_pkg::RST_SPIN_DUTY;
      trim_right_r   <= dccg_pkg::RST_TRIM_RIGHT;
      trim_left_r    <= dccg_pkg::RST_TRIM_LEFT;
      speed_step_r   <= dccg_pkg::RST_SPEED_STEP;
      brake_decel_r  <= dccg_pkg::RST_BRAKE_DECEL;
      reverse_duty_r <= dccg_pkg::RST_REVERSE_DUTY;
      reverse_ms_r   <= dccg_pkg::RST_REVERSE_MS;
    end else if (cfg_wr) begin
      unique case (dccg_pkg::cfg_idx_t'(cfg_paddr[4:2]))
        dccg_pkg::CFG_DRIVE_DUTY:     drive_duty_r   <= cfg_pwdata[7:0];
        dccg_pkg::CFG_SPIN_DUTY:      spin_duty_r    <= cfg_pwdata[7:0];
        dccg_pkg::CFG_TRIM_RIGHT:     trim_right_r   <= cfg_pwdata[8:0];
        dccg_pkg::CFG_TRIM_LEFT:      trim_left_r    <= cfg_pwdata[8:0];
        dccg_pkg::CFG_SPEED_PER_STEP: speed_step_r   <= cfg_pwdata[13:0];
        dccg_pkg::CFG_BRAKE_DECEL:    brake_decel_r  <= cfg_pwdata[13:0];
        dccg_pkg::CFG_REVERSE_DUTY:   reverse_duty_r <= cfg_pwdata[7:0];
        dccg_pkg::CFG_REVERSE_MS:     reverse_ms_r   <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (dccg_pkg::cfg_idx_t'(cfg_paddr[4:2]))
      dccg_pkg::CFG_DRIVE_DUTY:     cfg_prdata = {24'd0, drive_duty_r};
      dccg_pkg::CFG_SPIN_DUTY:      cfg_prdata = {24'd0, spin_duty_r};
      dccg_pkg::CFG_TRIM_RIGHT:     cfg_prdata = {23'd0, trim_right_r};
      dccg_pkg::CFG_TRIM_LEFT:      cfg_prdata = {23'd0, trim_left_r};
      dccg_pkg::CFG_SPEED_PER_STEP: cfg_prdata = {18'd0, speed_step_r};
      dccg_pkg::CFG_BRAKE_DECEL:    cfg_prdata = {18'd0, brake_decel_r};
      dccg_pkg::CFG_REVERSE_DUTY:   cfg_prdata = {24'd0, reverse_duty_r};
      dccg_pkg::CFG_REVERSE_MS:     cfg_prdata = {22'd0, reverse_ms_r};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  // drive speeds for straight and arc forward
  assign arc_sum   = {2'b00, drive_duty_r} + {1'b0, drive_duty_r, 1'b0};
  assign arc       = arc_sum[9:2];
  assign arc_left  = item_r.left_button && !item_r.right_button;
  assign arc_right = item_r.right_button && !item_r.left_button;
  always_comb begin
    pwm = drive_duty_r;
    rs  = drive_duty_r;
    ls  = drive_duty_r;
    if (arc_left) begin
      pwm = arc;
      rs  = arc;
      ls  = {1'b0, arc[7:1]};
    end else if (arc_right) begin
      pwm = arc;
      rs  = {1'b0, arc[7:1]};
      ls  = arc;
    end
  end

  assign decel        = (brake_decel_r == 14'd0) ? 14'd1 : brake_decel_r;
  assign seven_v      = {prod_r[21:0], 3'b000} - {3'b000, prod_r[21:0]};
  assign range_um     = prod_r[27:0];
  assign echo_timeout = (item_r.echo_us == 15'd0) ||
                        ({17'd0, item_r.echo_us} > 32'(ECHO_TIMEOUT_US));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      dccg_pkg::MS_ECHO: begin
        mul_a = {7'd0, item_r.echo_us};
        mul_b = dccg_pkg::RECIP_58;
      end
      dccg_pkg::MS_SPEED: begin
        mul_a = {14'd0, pwm};
        mul_b = {14'd0, speed_step_r};
      end
      dccg_pkg::MS_SQUARE: begin
        mul_a = prod_r[21:0];
        mul_b = {6'd0, prod_r[21:0]};
      end
      dccg_pkg::MS_RANGE: begin
        mul_a = {12'd0, cm_r};
        mul_b = dccg_pkg::UM20_PER_CM;
      end
      dccg_pkg::MS_DECEL: begin
        mul_a = {8'd0, decel};
        mul_b = dccg_pkg::DECEL_SCALE;
      end
      dccg_pkg::MS_MARGIN: begin
        mul_a = {1'b0, prod_r[20:0]};
        mul_b = w_r;
      end
      dccg_pkg::MS_COMPARE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {28'd0, mul_a} * {22'd0, mul_b};
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == dccg_pkg::ST_RUN) begin
      unique case (step_r)
        dccg_pkg::MS_SQUARE: b20_r <= (seven_v < dccg_pkg::MARGIN_FLOOR) ?
                                      dccg_pkg::MARGIN_FLOOR : seven_v;
        dccg_pkg::MS_RANGE:  vsq_r <= prod_r[43:0];
        dccg_pkg::MS_DECEL: begin
          wpos_r <= range_um > {3'd0, b20_r};
          w_r    <= range_um - {3'd0, b20_r};
        end
        dccg_pkg::MS_COMPARE: clear_r <= wpos_r && (prod_r > {6'd0, vsq_r});
        default: ;
      endcase
    end
    if (load) begin
      out_r <= out_nxt;
    end
  end

  // guard phase sequencing and drive decision for one tick
  always_comb begin
    logic [1:0] rd, ld;
    logic [7:0] rduty, lduty;
    logic       emerg;
    rd        = dccg_pkg::DIR_BRAKE;
    ld        = dccg_pkg::DIR_BRAKE;
    rduty     = 8'd0;
    lduty     = 8'd0;
    emerg     = 1'b0;
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    if (phase_r == dccg_pkg::PH_IDLE) begin
      if (item_r.fwd_button) begin
        if (clear_r) begin
          rd    = dccg_pkg::DIR_FWD;
          ld    = dccg_pkg::DIR_FWD;
          rduty = dccg_pkg::trimmed(rs, trim_right_r);
          lduty = dccg_pkg::trimmed(ls, trim_left_r);
        end else begin
          phase_nxt = dccg_pkg::PH_BRAKE;
          ticks_nxt = dccg_pkg::BRAKE_TICKS;
        end
      end else if (item_r.back_button) begin
        rd    = dccg_pkg::DIR_BACK;
        ld    = dccg_pkg::DIR_BACK;
        rduty = dccg_pkg::trimmed(drive_duty_r, trim_right_r);
        lduty = dccg_pkg::trimmed(drive_duty_r, trim_left_r);
      end else if (arc_left) begin
        rd    = dccg_pkg::DIR_FWD;
        ld    = dccg_pkg::DIR_BACK;
        rduty = dccg_pkg::trimmed(spin_duty_r, trim_right_r);
        lduty = dccg_pkg::trimmed(spin_duty_r, trim_left_r);
      end else if (arc_right) begin
        rd    = dccg_pkg::DIR_BACK;
        ld    = dccg_pkg::DIR_FWD;
        rduty = dccg_pkg::trimmed(spin_duty_r, trim_right_r);
        lduty = dccg_pkg::trimmed(spin_duty_r, trim_left_r);
      end
    end
    if (phase_nxt != dccg_pkg::PH_IDLE) begin
      emerg = 1'b1;
      unique case (phase_nxt)
        dccg_pkg::PH_BRAKE: begin
          rd = held_rd_r;
          ld = held_ld_r;
        end
        dccg_pkg::PH_REVERSE: begin
          rd    = dccg_pkg::DIR_BACK;
          ld    = dccg_pkg::DIR_BACK;
          rduty = reverse_duty_r;
          lduty = reverse_duty_r;
        end
        default: begin
          rd = dccg_pkg::DIR_BRAKE;
          ld = dccg_pkg::DIR_BRAKE;
        end
      endcase
      if (ticks_nxt > 10'd1) begin
        ticks_nxt = ticks_nxt - 10'd1;
      end else if (phase_nxt == dccg_pkg::PH_BRAKE && reverse_ms_r != 10'd0) begin
        phase_nxt = dccg_pkg::PH_REVERSE;
        ticks_nxt = reverse_ms_r;
      end else if (phase_nxt != dccg_pkg::PH_SETTLE) begin
        phase_nxt = dccg_pkg::PH_SETTLE;
        ticks_nxt = dccg_pkg::SETTLE_TICKS;
      end else begin
        phase_nxt = dccg_pkg::PH_IDLE;
        ticks_nxt = 10'd0;
      end
    end
    out_nxt.right_dir        = rd;
    out_nxt.right_duty       = rduty;
    out_nxt.left_dir         = ld;
    out_nxt.left_duty        = lduty;
    out_nxt.emergency_active = emerg;
    out_nxt.distance_now     = cm_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      dccg_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dccg_pkg::ST_RUN;
          step_nxt  = dccg_pkg::MS_ECHO;
        end
      end
      dccg_pkg::ST_RUN: begin
        if (step_r == dccg_pkg::MS_COMPARE) begin
          state_nxt = dccg_pkg::ST_FINISH;
        end else begin
          step_nxt = dccg_pkg::step_t'(step_r + 3'd1);
        end
      end
      dccg_pkg::ST_FINISH: begin
        if (load) begin
          state_nxt = dccg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dccg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dccg_pkg::ST_IDLE;
      step_r      <= dccg_pkg::MS_ECHO;
      out_valid_r <= 1'b0;
      cm_r        <= dccg_pkg::FAR_CM;
      phase_r     <= dccg_pkg::PH_IDLE;
      ticks_r     <= 10'd0;
      held_rd_r   <= dccg_pkg::DIR_COAST;
      held_ld_r   <= dccg_pkg::DIR_COAST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        ticks_r     <= ticks_nxt;
        held_rd_r   <= out_nxt.right_dir;
        held_ld_r   <= out_nxt.left_dir;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == dccg_pkg::ST_RUN && step_r == dccg_pkg::MS_SPEED &&
          item_r.echo_new) begin
        cm_r <= echo_timeout ? dccg_pkg::FAR_CM :
                prod_r[dccg_pkg::RECIP_SHIFT +: 10];
      end
    end
  end

  a_idle_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == dccg_pkg::PH_IDLE |-> ticks_r == 10'd0)
    else $error("idle guard phase with ticks pending");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == dccg_pkg::ST_RUN && step_r == dccg_pkg::MS_ECHO)
    else $error("accepted beat did not start the sequencer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == dccg_pkg::ST_FINISH)
    else $error("result appeared outside the finish step");

  a_distance_range: assert property (@(posedge clk) disable iff (!rst_n)
    cm_r <= dccg_pkg::FAR_CM)
    else $error("obstacle distance out of range");

endmodule

`default_nettype wire

// File: test/drive_command_collision_guard_core_test.sv
module drive_command_collision_guard_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ECHO_TIMEOUT_US = 25000;
  localparam int US_PER_CM = 58;
  localparam int NUM_OPENING = 20;
  localparam int NUM_PHASES = 7;
  localparam int TICKS_PER_PHASE = 165;
  localparam int LONG_HOLD_AT = 600;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 12;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic [7:0]        drive_duty;
    logic [7:0]        spin_duty;
    logic signed [8:0] trim_right;
    logic signed [8:0] trim_left;
    logic [13:0]       speed_step;
    logic [13:0]       brake_decel;
    logic [7:0]        reverse_duty;
    logic [9:0]        reverse_ms;
  } drive_cfg_t;

  typedef struct {
    dccg_pkg::in_t  beat;
    bit             typed;
    dccg_pkg::out_t want;
  } tick_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  dccg_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  dccg_pkg::out_t out_data;
  logic           cfg_psel = 1'b0;
  logic           cfg_penable = 1'b0;
  logic           cfg_pwrite = 1'b0;
  logic [4:0]     cfg_paddr = '0;
  logic [31:0]    cfg_pwdata = '0;
  logic [31:0]    cfg_prdata;
  logic           cfg_pready;

  drive_cfg_t       cfg_now;
  logic [9:0]       obstacle_cm;
  dccg_pkg::phase_t guard_phase;
  logic [9:0]       phase_ticks;
  logic [1:0]       held_right, held_left;
  dccg_pkg::out_t   pending_drive[$];
  int               mismatches = 0;
  bit               steady = 1'b0;

  always #10 clk = ~clk;

  drive_command_collision_guard_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // directed opening, run with the reset register values
  tick_row_t opening_ticks [NUM_OPENING] = '{
    '{'{0, 0, 0, 0, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_BRAKE, 8'd0, dccg_pkg::DIR_BRAKE, 8'd0, 1'b0, 10'd999}},
    '{'{0, 0, 0, 0, 1, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_BRAKE, 8'd0, dccg_pkg::DIR_BRAKE, 8'd0, 1'b0, 10'd999}},
    '{'{0, 0, 0, 0, 1, 15'd25001}, 1'b1,
      '{dccg_pkg::DIR_BRAKE, 8'd0, dccg_pkg::DIR_BRAKE, 8'd0, 1'b0, 10'd999}},
    '{'{0, 0, 0, 0, 1, 15'd32767}, 1'b1,
      '{dccg_pkg::DIR_BRAKE, 8'd0, dccg_pkg::DIR_BRAKE, 8'd0, 1'b0, 10'd999}},
    '{'{0, 1, 0, 0, 1, 15'd5800}, 1'b1,
      '{dccg_pkg::DIR_BACK, 8'd220, dccg_pkg::DIR_BACK, 8'd255, 1'b0, 10'd100}},
    '{'{0, 0, 1, 0, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_FWD, 8'd165, dccg_pkg::DIR_BACK, 8'd200, 1'b0, 10'd100}},
    '{'{0, 0, 0, 1, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_BACK, 8'd165, dccg_pkg::DIR_FWD, 8'd200, 1'b0, 10'd100}},
    '{'{0, 0, 1, 1, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_BRAKE, 8'd0, dccg_pkg::DIR_BRAKE, 8'd0, 1'b0, 10'd100}},
    '{'{1, 0, 0, 0, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_FWD, 8'd220, dccg_pkg::DIR_FWD, 8'd255, 1'b0, 10'd100}},
    '{'{1, 0, 1, 0, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_FWD, 8'd156, dccg_pkg::DIR_FWD, 8'd95, 1'b0, 10'd100}},
    '{'{1, 0, 0, 1, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_FWD, 8'd60, dccg_pkg::DIR_FWD, 8'd191, 1'b0, 10'd100}},
    '{'{1, 0, 1, 1, 0, 15'd0}, 1'b1,
      '{dccg_pkg::DIR_FWD, 8'd220, dccg_pkg::DIR_FWD, 8'd255, 1'b0, 10'd100}},
    '{'{0, 1, 1, 1, 1, 15'd25000}, 1'b0, '0},
    '{'{1, 1, 1, 1, 1, 15'd16384}, 1'b0, '0},
    '{'{1, 0, 0, 1, 1, 15'd1566}, 1'b0, '0},
    '{'{1, 0, 0, 0, 1, 15'd1566}, 1'b0, '0},
    '{'{1, 0, 0, 0, 1, 15'd1508}, 1'b0, '0},
    '{'{0, 1, 0, 0, 1, 15'd0}, 1'b0, '0},
    '{'{0, 0, 1, 0, 1, 15'd20000}, 1'b0, '0},
    '{'{1, 0, 0, 0, 0, 15'd0}, 1'b0, '0}
  };

  function automatic logic [7:0] clamp_duty(input logic [7:0] speed,
                                            input logic signed [8:0] trim);
    int s;
    s = int'(speed) + int'(trim);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  // exact stopping check, scaled so that nothing is rounded
  function automatic bit room_to_stop(input logic [7:0] pwm);
    longint unsigned a, v, d, m;
    a = (cfg_now.brake_decel == 0) ? 64'd1 : 64'(cfg_now.brake_decel);
    v = 64'(pwm) * 64'(cfg_now.speed_step);
    d = 64'(obstacle_cm) * 64'd10000;
    m = 64'd7 * v;
    if (m < 64'd4000000) m = 64'd4000000;
    return 64'd40000 * a * d > 64'd20 * v * v + 64'd2000 * a * m;
  endfunction

  function automatic dccg_pkg::out_t drive_for_tick(input dccg_pkg::in_t t);
    dccg_pkg::out_t o;
    logic [7:0]     arc, pwm, rs, ls;
    o = '0;
    o.right_dir = dccg_pkg::DIR_BRAKE;
    o.left_dir = dccg_pkg::DIR_BRAKE;
    if (t.echo_new) begin
      if (t.echo_us == 0 || int'(t.echo_us) > ECHO_TIMEOUT_US) obstacle_cm = dccg_pkg::FAR_CM;
      else obstacle_cm = 10'(int'(t.echo_us) / US_PER_CM);
    end
    if (guard_phase == dccg_pkg::PH_IDLE) begin
      if (t.fwd_button) begin
        arc = 8'((int'(cfg_now.drive_duty) * 3) / 4);
        pwm = cfg_now.drive_duty;
        rs = cfg_now.drive_duty;
        ls = cfg_now.drive_duty;
        if (t.left_button && !t.right_button) begin
          pwm = arc;
          rs = arc;
          ls = arc >> 1;
        end else if (t.right_button && !t.left_button) begin
          pwm = arc;
          rs = arc >> 1;
          ls = arc;
        end
        if (room_to_stop(pwm)) begin
          o.right_dir = dccg_pkg::DIR_FWD;
          o.left_dir = dccg_pkg::DIR_FWD;
          o.right_duty = clamp_duty(rs, cfg_now.trim_right);
          o.left_duty = clamp_duty(ls, cfg_now.trim_left);
        end else begin
          guard_phase = dccg_pkg::PH_BRAKE;
          phase_ticks = dccg_pkg::BRAKE_TICKS;
        end
      end else if (t.back_button) begin
        o.right_dir = dccg_pkg::DIR_BACK;
        o.left_dir = dccg_pkg::DIR_BACK;
        o.right_duty = clamp_duty(cfg_now.drive_duty, cfg_now.trim_right);
        o.left_duty = clamp_duty(cfg_now.drive_duty, cfg_now.trim_left);
      end else if (t.left_button != t.right_button) begin
        o.right_dir = t.left_button ? dccg_pkg::DIR_FWD : dccg_pkg::DIR_BACK;
        o.left_dir = t.left_button ? dccg_pkg::DIR_BACK : dccg_pkg::DIR_FWD;
        o.right_duty = clamp_duty(cfg_now.spin_duty, cfg_now.trim_right);
        o.left_duty = clamp_duty(cfg_now.spin_duty, cfg_now.trim_left);
      end
    end
    if (guard_phase != dccg_pkg::PH_IDLE) begin
      o.emergency_active = 1'b1;
      o.right_duty = '0;
      o.left_duty = '0;
      case (guard_phase)
        dccg_pkg::PH_BRAKE: begin
          o.right_dir = held_right;
          o.left_dir = held_left;
        end
        dccg_pkg::PH_REVERSE: begin
          o.right_dir = dccg_pkg::DIR_BACK;
          o.left_dir = dccg_pkg::DIR_BACK;
          o.right_duty = cfg_now.reverse_duty;
          o.left_duty = cfg_now.reverse_duty;
        end
        default: begin
          o.right_dir = dccg_pkg::DIR_BRAKE;
          o.left_dir = dccg_pkg::DIR_BRAKE;
        end
      endcase
      if (phase_ticks > 1) begin
        phase_ticks = phase_ticks - 1'b1;
      end else if (guard_phase == dccg_pkg::PH_BRAKE && cfg_now.reverse_ms != 0) begin
        guard_phase = dccg_pkg::PH_REVERSE;
        phase_ticks = cfg_now.reverse_ms;
      end else if (guard_phase != dccg_pkg::PH_SETTLE) begin
        guard_phase = dccg_pkg::PH_SETTLE;
        phase_ticks = dccg_pkg::SETTLE_TICKS;
      end else begin
        guard_phase = dccg_pkg::PH_IDLE;
        phase_ticks = '0;
      end
    end
    held_right = o.right_dir;
    held_left = o.left_dir;
    o.distance_now = obstacle_cm;
    return o;
  endfunction

  task automatic offer_tick(input dccg_pkg::in_t beat, input bit typed,
                            input dccg_pkg::out_t typed_want);
    int             gap;
    dccg_pkg::out_t predicted;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    predicted = drive_for_tick(beat);
    pending_drive.push_back(typed ? typed_want : predicted);
  endtask

  task automatic write_reg(input dccg_pkg::cfg_idx_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_drive_cfg(input drive_cfg_t c);
    write_reg(dccg_pkg::CFG_DRIVE_DUTY, {24'd0, c.drive_duty});
    write_reg(dccg_pkg::CFG_SPIN_DUTY, {24'd0, c.spin_duty});
    write_reg(dccg_pkg::CFG_TRIM_RIGHT, {23'd0, c.trim_right});
    write_reg(dccg_pkg::CFG_TRIM_LEFT, {23'd0, c.trim_left});
    write_reg(dccg_pkg::CFG_SPEED_PER_STEP, {18'd0, c.speed_step});
    write_reg(dccg_pkg::CFG_BRAKE_DECEL, {18'd0, c.brake_decel});
    write_reg(dccg_pkg::CFG_REVERSE_DUTY, {24'd0, c.reverse_duty});
    write_reg(dccg_pkg::CFG_REVERSE_MS, {22'd0, c.reverse_ms});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_now = c;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_drive(input dccg_pkg::out_t got, input dccg_pkg::out_t want);
    if (got.right_dir !== want.right_dir) begin
      $error("right_dir: expected %0d, got %0d", want.right_dir, got.right_dir);
      mismatches++;
    end
    if (got.right_duty !== want.right_duty) begin
      $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
      mismatches++;
    end
    if (got.left_dir !== want.left_dir) begin
      $error("left_dir: expected %0d, got %0d", want.left_dir, got.left_dir);
      mismatches++;
    end
    if (got.left_duty !== want.left_duty) begin
      $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
      mismatches++;
    end
    if (got.emergency_active !== want.emergency_active) begin
      $error("emergency_active: expected %0d, got %0d",
             want.emergency_active, got.emergency_active);
      mismatches++;
    end
    if (got.distance_now !== want.distance_now) begin
      $error("distance_now: expected %0d, got %0d", want.distance_now, got.distance_now);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        $error("out beat with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        compare_drive(out_data, pending_drive.pop_front());
      end
    end
  end

  // result side: short random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    drive_cfg_t    c;
    dccg_pkg::in_t beat;
    int            pick;
    int            echo;
    cfg_now = '{drive_duty: dccg_pkg::RST_DRIVE_DUTY, spin_duty: dccg_pkg::RST_SPIN_DUTY,
                trim_right: dccg_pkg::RST_TRIM_RIGHT, trim_left: dccg_pkg::RST_TRIM_LEFT,
                speed_step: dccg_pkg::RST_SPEED_STEP, brake_decel: dccg_pkg::RST_BRAKE_DECEL,
                reverse_duty: dccg_pkg::RST_REVERSE_DUTY,
                reverse_ms: dccg_pkg::RST_REVERSE_MS};
    obstacle_cm = dccg_pkg::FAR_CM;
    guard_phase = dccg_pkg::PH_IDLE;
    phase_ticks = '0;
    held_right = dccg_pkg::DIR_COAST;
    held_left = dccg_pkg::DIR_COAST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_OPENING; i++) begin
      offer_tick(opening_ticks[i].beat, opening_ticks[i].typed, opening_ticks[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      c.drive_duty = 8'($urandom_range(0, 255));
      c.spin_duty = 8'($urandom_range(0, 255));
      c.trim_right = 9'(int'($urandom_range(0, 510)) - 255);
      c.trim_left = 9'(int'($urandom_range(0, 510)) - 255);
      c.speed_step = 14'($urandom_range(0, 10000));
      c.brake_decel = 14'($urandom_range(1, 10000));
      c.reverse_duty = 8'($urandom_range(0, 255));
      c.reverse_ms = 10'($urandom_range(1, 30));
      case (p)
        0: begin
          c = '{drive_duty: 8'd0, spin_duty: 8'd0, trim_right: -9'sd255,
                trim_left: -9'sd255, speed_step: 14'd0, brake_decel: 14'd1,
                reverse_duty: 8'd0, reverse_ms: 10'd0};
        end
        1: begin
          c = '{drive_duty: 8'd255, spin_duty: 8'd255, trim_right: 9'sd255,
                trim_left: 9'sd255, speed_step: 14'd10000, brake_decel: 14'd10000,
                reverse_duty: 8'd255, reverse_ms: 10'd5};
        end
        2: c.brake_decel = '0;
        NUM_PHASES - 1: c.reverse_ms = 10'd1000;
        default: ;
      endcase
      steady = (p % 3 == 2);
      drain();
      load_drive_cfg(c);

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        beat.fwd_button = ($urandom_range(0, 9) < 6);
        beat.back_button = 1'($urandom_range(0, 1));
        beat.left_button = 1'($urandom_range(0, 1));
        beat.right_button = 1'($urandom_range(0, 1));
        beat.echo_new = ($urandom_range(0, 9) < 6);
        pick = $urandom_range(0, 19);
        if (pick < 7) echo = $urandom_range(0, 4000);
        else if (pick < 10) echo = $urandom_range(0, 12000);
        else if (pick < 11) echo = 0;
        else if (pick < 13) echo = $urandom_range(ECHO_TIMEOUT_US + 1, 32767);
        else echo = $urandom_range(0, 32767);
        beat.echo_us = 15'(echo);
        offer_tick(beat, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_drive.size() != 0) begin
      $error("%0d expected beats never arrived", pending_drive.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
